// ----- hdl/nearest_tempered_note_estimator_defines.svh -----
// ----------------------------------------------------------------------------
// nearest_tempered_note_estimator_defines
// Assertion macros used by the note estimator controller.
// ----------------------------------------------------------------------------
`ifndef NEAREST_TEMPERED_NOTE_ESTIMATOR_DEFINES_SVH
`define NEAREST_TEMPERED_NOTE_ESTIMATOR_DEFINES_SVH
`ifndef SYNTH
`define NTE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NTE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NTE_ASSERT(lbl, prop, msg)
`define NTE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hdl/nte_pkg.sv -----
// ----------------------------------------------------------------------------
// nte_pkg
// Shared constants, types and tables of the note estimator.
// ----------------------------------------------------------------------------
package nte_pkg;

    localparam int LOG_FRAC_BITS = 16;
    localparam int FREQ_W = 24;
    localparam int REF_W  = 22;
    localparam int IDX_W  = 4;
    localparam int OCT_W  = 4;
    localparam int CENT_W = 13;
    localparam int MANT_W = 31;
    localparam int PROD_W = 2 * MANT_W;
    localparam int CNT_W  = $clog2(LOG_FRAC_BITS);

    localparam logic [REF_W-1:0]  REF_MIN   = 22'd409600;
    localparam logic [REF_W-1:0]  REF_MAX   = 22'd4096000;
    localparam logic [REF_W-1:0]  REF_RESET = 22'd1802240;
    localparam logic [FREQ_W-1:0] FREQ_LO   = 24'd163840;
    localparam logic [FREQ_W-1:0] FREQ_HI   = 24'd8192000;

    // upper and lower window edges, Q1.30
    localparam logic [MANT_W-1:0] UQ_K = 31'd2071693895;
    localparam logic [MANT_W-1:0] LQ_K = 31'd1029002581;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_MUL_UQ,
        OP_MUL_LQ,
        OP_OCT_UP,
        OP_OCT_DN,
        OP_NORM_F,
        OP_NORM_F0,
        OP_SQ,
        OP_NOTE,
        OP_MUL_NF,
        OP_FIN
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic in_range;
        logic up_go;
        logic dn_go;
        logic out_free;
    } sts_t;

    function automatic logic [MANT_W-1:0] semi_ratio(input logic [IDX_W-1:0] k);
        logic [MANT_W-1:0] r;
        case (k)
            4'd0:    r = 31'd1073741824;
            4'd1:    r = 31'd1137589835;
            4'd2:    r = 31'd1205234447;
            4'd3:    r = 31'd1276901417;
            4'd4:    r = 31'd1352829926;
            4'd5:    r = 31'd1433273380;
            4'd6:    r = 31'd1518500250;
            4'd7:    r = 31'd1608794973;
            4'd8:    r = 31'd1704458901;
            4'd9:    r = 31'd1805811301;
            4'd10:   r = 31'd1913190429;
            4'd11:   r = 31'd2026954652;
            default: r = 31'd1073741824;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/nte_ifs.sv -----
// ----------------------------------------------------------------------------
// nte channel interfaces
// Valid/ready channels for samples, results and the reference register.
// ----------------------------------------------------------------------------
interface nte_in_if;
    logic                      valid;
    logic                      ready;
    logic [nte_pkg::FREQ_W-1:0] measured_freq;
    modport source (output valid, output measured_freq, input ready);
    modport sink (input valid, input measured_freq, output ready);
endinterface

interface nte_out_if;
    logic                             valid;
    logic                             ready;
    logic                             valid_res;
    logic [nte_pkg::IDX_W-1:0]        note_index;
    logic signed [nte_pkg::OCT_W-1:0] octave_offset;
    logic signed [nte_pkg::CENT_W-1:0] cents_deviation;
    logic [nte_pkg::FREQ_W-1:0]       note_freq;
    modport source (output valid, output valid_res, output note_index, output octave_offset,
                    output cents_deviation, output note_freq, input ready);
    modport sink (input valid, input valid_res, input note_index, input octave_offset,
                  input cents_deviation, input note_freq, output ready);
endinterface

interface nte_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [nte_pkg::REF_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/nte_datapath.sv -----
// ----------------------------------------------------------------------------
// nte_datapath
// Octave search, log2 by squaring, note pick and result register.
// ----------------------------------------------------------------------------
module nte_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  nte_pkg::cmd_t                     cmd,
    output nte_pkg::sts_t                     sts,
    input  logic [nte_pkg::FREQ_W-1:0]        measured_freq,
    input  logic                              cfg_we,
    input  logic [nte_pkg::REF_W-1:0]         cfg_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              valid_res,
    output logic [nte_pkg::IDX_W-1:0]         note_index,
    output logic signed [nte_pkg::OCT_W-1:0]  octave_offset,
    output logic signed [nte_pkg::CENT_W-1:0] cents_deviation,
    output logic [nte_pkg::FREQ_W-1:0]        note_freq
);
    import nte_pkg::*;

    localparam int FB  = LOG_FRAC_BITS;
    localparam int LW  = 5 + FB;
    localparam int TW  = LW + 6;
    localparam int CS  = (FB >= 12) ? FB - 12 : 0;
    localparam int CL  = (FB < 12) ? 12 - FB : 0;
    localparam int RND = (CS == 0) ? 0 : 2 ** (CS - 1);
    localparam int HALFM = 2 ** (FB - 1) - 1;

    logic [REF_W-1:0]         ref_reg;
    logic [FREQ_W-1:0]        f_reg;
    logic [REF_W-1:0]         f0_reg;
    logic                     in_range_reg;
    logic signed [OCT_W-1:0]  oct_reg;
    logic [PROD_W-1:0]        q_reg;
    logic [MANT_W-1:0]        m_reg;
    logic [4:0]               ip_reg;
    logic [FB-1:0]            frac_reg;
    logic [LW-1:0]            lf_reg;
    logic [IDX_W-1:0]         best_reg;
    logic signed [CENT_W-1:0] cents_reg;
    logic                     out_valid_reg;
    logic                     res_valid_reg;
    logic [IDX_W-1:0]         res_idx_reg;
    logic signed [OCT_W-1:0]  res_oct_reg;
    logic signed [CENT_W-1:0] res_cents_reg;
    logic [FREQ_W-1:0]        res_nf_reg;

    function automatic logic [4:0] lead_one(input logic [FREQ_W-1:0] v);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < FREQ_W; i++)
        begin
            if (v[i])
            begin
                p = 5'(i);
            end
        end
        return p;
    endfunction

    // shared multiplier
    logic [MANT_W-1:0] mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;
    always_comb
    begin
        case (cmd.op)
            OP_MUL_UQ:
            begin
                mul_a = {{(MANT_W-REF_W){1'b0}}, f0_reg};
                mul_b = UQ_K;
            end
            OP_MUL_LQ:
            begin
                mul_a = {{(MANT_W-REF_W){1'b0}}, f0_reg};
                mul_b = LQ_K;
            end
            OP_MUL_NF:
            begin
                mul_a = {{(MANT_W-REF_W){1'b0}}, f0_reg};
                mul_b = semi_ratio(best_reg);
            end
            default:
            begin
                mul_a = m_reg;
                mul_b = m_reg;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // scaled window compare
    logic [3:0]  nsh, psh;
    logic [63:0] lhs, rhs;
    always_comb
    begin
        nsh = oct_reg[3] ? 4'(5'd0 - {oct_reg[3], oct_reg}) : 4'd0;
        psh = oct_reg[3] ? 4'd0 : oct_reg;
        lhs = {10'd0, f_reg, 30'd0} << nsh;
        rhs = {{(64-PROD_W){1'b0}}, q_reg} << psh;
    end

    // normalize
    logic [FREQ_W-1:0] norm_src;
    logic [4:0]        norm_ip;
    logic [MANT_W-1:0] norm_m;
    always_comb
    begin
        norm_src = (cmd.op == OP_NORM_F0) ? {{(FREQ_W-REF_W){1'b0}}, f0_reg} : f_reg;
        norm_ip  = lead_one(norm_src);
        norm_m   = {{(MANT_W-FREQ_W){1'b0}}, norm_src} << (5'd30 - norm_ip);
    end

    logic [31:0] msq;
    assign msq = mul_p[61:30];

    // note selection
    logic signed [LW+1:0] t_pos;
    logic signed [TW-1:0] t12, rnd_sum, best_w, dev;
    logic signed [TW-1:0] cents_w;
    logic [IDX_W-1:0]     best_n;
    logic signed [CENT_W-1:0] cents_n;
    always_comb
    begin
        t_pos = $signed({2'b00, lf_reg}) - $signed({2'b00, ip_reg, frac_reg})
              - ($signed({{(LW+2-OCT_W){oct_reg[3]}}, oct_reg}) <<< FB);
        t12 = ($signed({{4{t_pos[LW+1]}}, t_pos}) <<< 3)
            + ($signed({{4{t_pos[LW+1]}}, t_pos}) <<< 2);
        rnd_sum = t12 + TW'(HALFM);
        best_w  = rnd_sum >>> FB;
        if (best_w < 0)
        begin
            best_n = 4'd0;
        end
        else if (best_w > TW'(11))
        begin
            best_n = 4'd11;
        end
        else
        begin
            best_n = best_w[IDX_W-1:0];
        end
        dev = t12 - ($signed({{(TW-IDX_W){1'b0}}, best_n}) <<< FB);
        if (FB >= 12)
        begin
            cents_w = (dev + TW'(RND)) >>> CS;
        end
        else
        begin
            cents_w = dev <<< CL;
        end
        if (cents_w < -TW'(4096))
        begin
            cents_n = -13'sd4096;
        end
        else if (cents_w > TW'(4095))
        begin
            cents_n = 13'sd4095;
        end
        else
        begin
            cents_n = cents_w[CENT_W-1:0];
        end
    end

    // note frequency rounding
    logic signed [6:0] shs;
    logic [5:0]        sh;
    logic [63:0]       nf_full;
    logic [FREQ_W-1:0] nf_sat;
    always_comb
    begin
        shs = 7'sd30 - $signed({{3{oct_reg[3]}}, oct_reg});
        sh  = shs[5:0];
        nf_full = ({{(64-PROD_W){1'b0}}, q_reg} + (64'd1 << (sh - 6'd1))) >> sh;
        nf_sat  = (nf_full > 64'hFFFFFF) ? 24'hFFFFFF : nf_full[FREQ_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg       <= REF_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ref_reg <= cfg_data;
            end
            if (cmd.op == OP_FIN)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CAPTURE:
            begin
                f_reg        <= measured_freq;
                in_range_reg <= (measured_freq >= FREQ_LO) && (measured_freq <= FREQ_HI);
                f0_reg       <= (ref_reg < REF_MIN) ? REF_MIN :
                                (ref_reg > REF_MAX) ? REF_MAX : ref_reg;
                oct_reg      <= '0;
            end
            OP_MUL_UQ, OP_MUL_LQ, OP_MUL_NF:
            begin
                q_reg <= mul_p;
            end
            OP_OCT_UP:
            begin
                oct_reg <= oct_reg + 4'sd1;
            end
            OP_OCT_DN:
            begin
                oct_reg <= oct_reg - 4'sd1;
            end
            OP_NORM_F, OP_NORM_F0:
            begin
                if (cmd.op == OP_NORM_F0)
                begin
                    lf_reg <= {ip_reg, frac_reg};
                end
                ip_reg   <= norm_ip;
                m_reg    <= norm_m;
                frac_reg <= '0;
            end
            OP_SQ:
            begin
                frac_reg <= {frac_reg[FB-2:0], msq[31]};
                m_reg    <= msq[31] ? msq[31:1] : msq[30:0];
            end
            OP_NOTE:
            begin
                best_reg  <= best_n;
                cents_reg <= cents_n;
            end
            OP_FIN:
            begin
                res_valid_reg <= in_range_reg;
                res_idx_reg   <= in_range_reg ? best_reg : '0;
                res_oct_reg   <= in_range_reg ? oct_reg : '0;
                res_cents_reg <= in_range_reg ? cents_reg : '0;
                res_nf_reg    <= in_range_reg ? nf_sat : '0;
            end
            default:
            begin
            end
        endcase
    end

    assign sts.in_range = in_range_reg;
    assign sts.up_go    = (oct_reg != 4'sd7) && (lhs > rhs);
    assign sts.dn_go    = (oct_reg != -4'sd8) && (lhs < rhs);
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign valid_res       = res_valid_reg;
    assign note_index      = res_idx_reg;
    assign octave_offset   = res_oct_reg;
    assign cents_deviation = res_cents_reg;
    assign note_freq       = res_nf_reg;

endmodule

// ----- hdl/nte_controller.sv -----
// ----------------------------------------------------------------------------
// nte_controller
// Sequencer that steps the datapath through one estimate.
// ----------------------------------------------------------------------------
`include "nearest_tempered_note_estimator_defines.svh"

module nte_controller (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  nte_pkg::sts_t sts,
    output nte_pkg::cmd_t cmd
);
    import nte_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_CHECK   = 13'b0000000000010,
        S_MUL_UQ  = 13'b0000000000100,
        S_UP      = 13'b0000000001000,
        S_MUL_LQ  = 13'b0000000010000,
        S_DN      = 13'b0000000100000,
        S_NORM_F  = 13'b0000001000000,
        S_SQ_F    = 13'b0000010000000,
        S_NORM_F0 = 13'b0000100000000,
        S_SQ_F0   = 13'b0001000000000,
        S_NOTE    = 13'b0010000000000,
        S_MUL_NF  = 13'b0100000000000,
        S_FIN     = 13'b1000000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             cnt_last;

    assign cnt_last = (cnt_reg == CNT_W'(LOG_FRAC_BITS - 1));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = sts.in_range ? S_MUL_UQ : S_FIN;
            end
            S_MUL_UQ:
            begin
                cmd.op     = OP_MUL_UQ;
                state_next = S_UP;
            end
            S_UP:
            begin
                if (sts.up_go)
                begin
                    cmd.op = OP_OCT_UP;
                end
                else
                begin
                    state_next = S_MUL_LQ;
                end
            end
            S_MUL_LQ:
            begin
                cmd.op     = OP_MUL_LQ;
                state_next = S_DN;
            end
            S_DN:
            begin
                if (sts.dn_go)
                begin
                    cmd.op = OP_OCT_DN;
                end
                else
                begin
                    state_next = S_NORM_F;
                end
            end
            S_NORM_F:
            begin
                cmd.op     = OP_NORM_F;
                cnt_next   = '0;
                state_next = S_SQ_F;
            end
            S_SQ_F:
            begin
                cmd.op   = OP_SQ;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = S_NORM_F0;
                end
            end
            S_NORM_F0:
            begin
                cmd.op     = OP_NORM_F0;
                state_next = S_SQ_F0;
            end
            S_SQ_F0:
            begin
                cmd.op   = OP_SQ;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = S_NOTE;
                end
            end
            S_NOTE:
            begin
                cmd.op     = OP_NOTE;
                state_next = S_MUL_NF;
            end
            S_MUL_NF:
            begin
                cmd.op     = OP_MUL_NF;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // hold until the result register can take the transaction
                if (sts.out_free)
                begin
                    cmd.op     = OP_FIN;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    `NTE_ASSERT(a_accept_check, (in_valid && in_ready) |=> (state_reg == S_CHECK), "accept must start a pass")
    `NTE_ASSERT(a_fin_free, (cmd.op == OP_FIN) |-> sts.out_free, "result written while occupied")
    `NTE_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= CNT_W'(LOG_FRAC_BITS - 1), "square counter overrun")

endmodule

// ----- hdl/nearest_tempered_note_estimator.sv -----
// ----------------------------------------------------------------------------
// nearest_tempered_note_estimator
// Nearest equal-tempered note, octave, deviation and note frequency.
// ----------------------------------------------------------------------------
// One sample is processed at a time. An in-range sample occupies the block for
// the octave search, one step per octave, and two passes of FB squaring
// iterations (FB = LOG_FRAC_BITS = 16) through the single shared 31x31
// multiplier; an out-of-range sample skips them. Both wait longer when the
// previous result is still held in the output register. A finished result
// waits in the output register while the next sample is accepted.
module nearest_tempered_note_estimator (
    input logic      clk,
    input logic      rst_n,
    nte_in_if.sink   sample,
    nte_cfg_if.sink  cfg,
    nte_out_if.source result
);
    import nte_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg.ready = 1'b1;

    nte_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (sample.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    nte_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .measured_freq   (sample.measured_freq),
        .cfg_we          (cfg.valid),
        .cfg_data        (cfg.data),
        .out_valid       (result.valid),
        .out_ready       (result.ready),
        .valid_res       (result.valid_res),
        .note_index      (result.note_index),
        .octave_offset   (result.octave_offset),
        .cents_deviation (result.cents_deviation),
        .note_freq       (result.note_freq)
    );

endmodule

// ----- tb/sv/nearest_tempered_note_estimator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_tempered_note_estimator_test
// Drives frequency samples and reference writes into the note estimator and
// checks every result against an in-bench bit-exact note predictor.
// ----------------------------------------------------------------------------
import nte_pkg::*;

typedef struct packed {
    logic                     valid_res;
    logic [IDX_W-1:0]         note_index;
    logic signed [OCT_W-1:0]  octave_offset;
    logic signed [CENT_W-1:0] cents_deviation;
    logic [FREQ_W-1:0]        note_freq;
} note_res_t;

class note_scoreboard;
    logic [REF_W-1:0] ref_freq;
    note_res_t        pending[$];
    int               mismatches;
    int               checked;
    int               in_range_cnt;
    int               notes_seen[12];
    int               octs_seen[16];

    function new();
        ref_freq = REF_RESET;
        mismatches = 0;
        checked = 0;
        in_range_cnt = 0;
        foreach (notes_seen[i]) notes_seen[i] = 0;
        foreach (octs_seen[i]) octs_seen[i] = 0;
    endfunction

    static function logic [63:0] tone_ratio(int k);
        logic [63:0] tab[12];
        tab = '{64'd1073741824, 64'd1137589835, 64'd1205234447, 64'd1276901417,
                64'd1352829926, 64'd1433273380, 64'd1518500250, 64'd1608794973,
                64'd1704458901, 64'd1805811301, 64'd1913190429, 64'd2026954652};
        return tab[k];
    endfunction

    // f * 2^-oct against edge q, both scaled by 2^30
    static function int edge_cmp(logic [63:0] f, logic [63:0] q, int oct);
        logic [63:0] lhs;
        logic [63:0] rhs;
        lhs = f << 30;
        rhs = q;
        if (oct < 0) lhs = lhs << (-oct);
        else rhs = rhs << oct;
        if (lhs > rhs) return 1;
        if (lhs < rhs) return -1;
        return 0;
    endfunction

    static function longint log2_q(logic [63:0] v);
        int          ip;
        logic [63:0] m;
        logic [63:0] fr;
        logic [127:0] sq;
        ip = 0;
        fr = 0;
        while (ip < 31 && (v >> (ip + 1)) != 0) ip++;
        m = v << (30 - ip);
        for (int i = 0; i < LOG_FRAC_BITS; i++) begin
            sq = m * m;
            m = sq[93:30];
            fr = fr << 1;
            if (m >= 64'h8000_0000) begin
                fr = fr | 1;
                m = m >> 1;
            end
        end
        return longint'((64'(ip) << LOG_FRAC_BITS) | fr);
    endfunction

    function note_res_t predict_note(logic [FREQ_W-1:0] freq);
        note_res_t   r;
        logic [63:0] f, f0, uq, lq, prod, nf;
        longint      t12, d, dev, best_d, cents;
        int          oct, best, sh;
        r = '0;
        f = freq;
        if (freq < FREQ_LO || freq > FREQ_HI) return r;
        f0 = ref_freq;
        if (f0 < REF_MIN) f0 = REF_MIN;
        if (f0 > REF_MAX) f0 = REF_MAX;
        uq = f0 * (tone_ratio(11) + 64'd44739243);
        lq = f0 * (64'd1073741824 - 64'd44739243);
        oct = 0;
        while (oct < 7 && edge_cmp(f, uq, oct) > 0) oct++;
        while (oct > -8 && edge_cmp(f, lq, oct) < 0) oct--;
        t12 = 12 * (log2_q(f) - log2_q(f0) - longint'(oct) * (longint'(1) << LOG_FRAC_BITS));
        best_d = 64'sh7fff_ffff_ffff_ffff;
        best = 0;
        for (int k = 0; k < 12; k++) begin
            d = t12 - longint'(k) * (longint'(1) << LOG_FRAC_BITS);
            if (d < 0) d = -d;
            if (d < best_d) begin
                best_d = d;
                best = k;
            end
        end
        dev = t12 - longint'(best) * (longint'(1) << LOG_FRAC_BITS);
        // round half up to 1/4096 semitone
        cents = ((dev + (longint'(16) << LOG_FRAC_BITS) + (longint'(1) << (LOG_FRAC_BITS - 13)))
                 >>> (LOG_FRAC_BITS - 12)) - 65536;
        if (cents < -4096) cents = -4096;
        if (cents > 4095) cents = 4095;
        prod = f0 * tone_ratio(best);
        sh = 30 - oct;
        nf = (prod + (64'd1 << (sh - 1))) >> sh;
        if (nf > 64'hFF_FFFF) nf = 64'hFF_FFFF;
        r.valid_res = 1'b1;
        r.note_index = best[IDX_W-1:0];
        r.octave_offset = oct[OCT_W-1:0];
        r.cents_deviation = cents[CENT_W-1:0];
        r.note_freq = nf[FREQ_W-1:0];
        return r;
    endfunction

    function void note_sample(logic [FREQ_W-1:0] freq);
        note_res_t r;
        r = predict_note(freq);
        pending.push_back(r);
        if (r.valid_res) begin
            in_range_cnt++;
            notes_seen[r.note_index]++;
            octs_seen[r.octave_offset + 8]++;
        end
    endfunction

    function void check_result(note_res_t got);
        note_res_t want;
        checked++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
        end
        want = pending.pop_front();
        if (got.valid_res !== want.valid_res || got.note_index !== want.note_index ||
            got.octave_offset !== want.octave_offset ||
            got.cents_deviation !== want.cents_deviation || got.note_freq !== want.note_freq) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected %p, got %p", want, got);
        end
    endfunction
endclass

module nearest_tempered_note_estimator_test;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    int   cycles = 0;
    bit   calm;
    int   notes_hit;

    nte_in_if  sample();
    nte_cfg_if cfg();
    nte_out_if result();

    nearest_tempered_note_estimator dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample(sample),
        .cfg(cfg),
        .result(result)
    );

    note_scoreboard sb;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[nearest_tempered_note_estimator] ERROR");
            $finish;
        end
    end

    // result side: random stall bursts, check on each transaction
    initial
    begin
        int hold;
        result.ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                hold = $urandom_range(1, 9);
                result.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            result.ready <= 1'b1;
            @(posedge clk);
            if (result.valid && result.ready)
                sb.check_result('{result.valid_res, result.note_index, result.octave_offset,
                                  result.cents_deviation, result.note_freq});
        end
    end

    // valid stays high after a transaction until an idle burst or a drain drops it
    task automatic send_sample(logic [FREQ_W-1:0] freq);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            sample.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        sample.valid <= 1'b1;
        sample.measured_freq <= freq;
        @(posedge clk);
        while (!sample.ready) @(posedge clk);
        sb.note_sample(freq);
    endtask

    task automatic drain();
        sample.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reference(logic [REF_W-1:0] value);
        drain();
        cfg.valid <= 1'b1;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
        sb.ref_freq = value;
    endtask

    // mostly in-range musical frequencies, some full-range noise
    function automatic logic [FREQ_W-1:0] pick_freq();
        case ($urandom_range(0, 9))
            0:       return FREQ_W'($urandom_range(0, 24'hFF_FFFF));
            1:       return FREQ_W'($urandom_range(0, FREQ_LO));
            2:       return FREQ_W'($urandom_range(FREQ_HI - 16, FREQ_HI + 16));
            3:       return FREQ_W'($urandom_range(FREQ_LO - 4, FREQ_LO + 4));
            default: return FREQ_W'($urandom_range(FREQ_LO, FREQ_HI));
        endcase
    endfunction

    initial
    begin
        logic [REF_W-1:0] refs[7];
        sb = new();
        calm = 1'b0;
        rst_n = 1'b0;
        sample.valid = 1'b0;
        sample.measured_freq = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: range edges, bit extremes, exact notes
        send_sample('0);
        send_sample(24'hFF_FFFF);
        send_sample(FREQ_LO - 1);
        send_sample(FREQ_LO);
        send_sample(FREQ_HI);
        send_sample(FREQ_HI + 1);
        send_sample(24'hAA_AAAA);
        send_sample(24'h55_5555);
        send_sample(24'd1802240);
        for (int k = 0; k < 12; k++)
            send_sample(24'((64'd1802240 * sb.tone_ratio(k)) >> 30));
        send_sample(24'd1802240 - 24'd75093);
        send_sample(24'd1802240 + 24'd3);

        refs = '{22'd409600, 22'd4096000, 22'd0, 22'h3F_FFFF, 22'd1000000, 22'h15_5555,
                 REF_RESET};
        for (int p = 0; p < 7; p++)
        begin
            write_reference(p < 6 ? refs[p] : 22'($urandom_range(409600, 4096000)));
            if (p == 3) drain();
            for (int i = 0; i < 68; i++)
            begin
                if (p == 6 && i > 40) calm = 1'b1;
                send_sample(pick_freq());
            end
        end
        write_reference(REF_RESET);
        for (int i = 0; i < 20; i++) send_sample(pick_freq());

        drain();
        notes_hit = 0;
        foreach (sb.notes_seen[i]) if (sb.notes_seen[i] > 0) notes_hit++;
        $display("%0d results checked, %0d in range, %0d of 12 notes seen, 8 reference settings",
                 sb.checked, sb.in_range_cnt, notes_hit);
        if (sb.mismatches == 0)
            $display("[nearest_tempered_note_estimator] OK");
        else
        begin
            $display("%0d mismatches", sb.mismatches);
            $display("[nearest_tempered_note_estimator] ERROR");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/nte_pkg.sv
hdl/nte_ifs.sv
hdl/nte_datapath.sv
hdl/nte_controller.sv
hdl/nearest_tempered_note_estimator.sv
tb/sv/nearest_tempered_note_estimator_test.sv
